// File: src/pt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pt_pkg
// Shared types and constants of the park transform pipeline: the word that
// travels through the cordic stages, quadrant codes and the arctangent table.
// ----------------------------------------------------------------------------
package pt_pkg;

    localparam int ATAN_ENTRIES = 24;

    // gain compensation 0.60725293 in q1.30
    localparam logic signed [31:0] CORDIC_GAIN_Q30 = 32'sd652032874;

    // half of a quadrant in angle counts, used to centre the residual angle
    localparam logic [15:0] EIGHTH_TURN = 16'd8192;

    // atan(2^-i) in 32-bit turn units, rounded
    localparam logic signed [31:0] ATAN_TABLE [ATAN_ENTRIES] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    typedef enum logic [1:0] {
        QUAD_0 = 2'd0,
        QUAD_1 = 2'd1,
        QUAD_2 = 2'd2,
        QUAD_3 = 2'd3
    } pt_quad_t;

    // one word in flight through the rotator
    typedef struct packed {
        logic signed [15:0] alpha;
        logic signed [15:0] beta;
        pt_quad_t           quad;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } pt_cordic_t;

endpackage

// File: src/pt_fold.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pt_fold
// Input register stage: folds the binary angle into a quadrant and a residual
// in [-pi/4, pi/4) and seeds the cordic with the gain-compensated unit vector.
// ----------------------------------------------------------------------------
module pt_fold
    import pt_pkg::*;
(
    input  logic               aclk,
    input  logic               en,
    input  logic signed [15:0] alpha_in,
    input  logic signed [15:0] beta_in,
    input  logic [15:0]        rotor_angle,
    output pt_cordic_t         word_out
);

    logic [15:0]        shifted;
    logic signed [14:0] residual;
    pt_cordic_t         word_next;
    pt_cordic_t         word_reg;

    always_comb begin
        shifted  = rotor_angle + EIGHTH_TURN;
        residual = $signed({1'b0, shifted[13:0]}) - $signed(15'sd8192);
        word_next.alpha = alpha_in;
        word_next.beta  = beta_in;
        word_next.quad  = pt_quad_t'(shifted[15:14]);
        word_next.x     = CORDIC_GAIN_Q30;
        word_next.y     = 32'sd0;
        // residual scaled to 32-bit turn units
        word_next.z     = {residual[14], residual, 16'h0000};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            word_reg <= word_next;
        end
    end

    assign word_out = word_reg;

endmodule

// File: src/pt_cordic_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pt_cordic_stage
// One registered micro-rotation of the rotation-mode cordic.
// ----------------------------------------------------------------------------
module pt_cordic_stage
    import pt_pkg::*;
#(
    parameter int STAGE_IDX = 0
) (
    input  logic       aclk,
    input  logic       en,
    input  pt_cordic_t word_in,
    output pt_cordic_t word_out
);

    logic signed [31:0] dx;
    logic signed [31:0] dy;
    pt_cordic_t         word_next;
    pt_cordic_t         word_reg;

    always_comb begin
        dx = word_in.y >>> STAGE_IDX;
        dy = word_in.x >>> STAGE_IDX;
        word_next = word_in;
        if (!word_in.z[31]) begin
            word_next.x = word_in.x - dx;
            word_next.y = word_in.y + dy;
            word_next.z = word_in.z - ATAN_TABLE[STAGE_IDX];
        end else begin
            word_next.x = word_in.x + dx;
            word_next.y = word_in.y - dy;
            word_next.z = word_in.z + ATAN_TABLE[STAGE_IDX];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            word_reg <= word_next;
        end
    end

    assign word_out = word_reg;

endmodule

// File: src/pt_rotate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pt_rotate
// Maps the cordic result to cos/sin by quadrant, forms the four products in
// one stage and the rounded d/q sums in the next.
// ----------------------------------------------------------------------------
module pt_rotate
    import pt_pkg::*;
(
    input  logic               aclk,
    input  logic               en,
    input  pt_cordic_t         word_in,
    output logic signed [16:0] direct_out,
    output logic signed [16:0] quadrature_out
);

    logic signed [31:0] cos_val;
    logic signed [31:0] sin_val;

    logic signed [47:0] ac_next, as_next, bc_next, bs_next;
    logic signed [47:0] ac_reg, as_reg, bc_reg, bs_reg;

    logic signed [48:0] d_sum;
    logic signed [48:0] q_sum;
    logic signed [48:0] d_rnd;
    logic signed [48:0] q_rnd;
    logic signed [16:0] direct_next, quadrature_next;
    logic signed [16:0] direct_reg, quadrature_reg;

    always_comb begin
        case (word_in.quad)
            QUAD_0: begin
                cos_val = word_in.x;
                sin_val = word_in.y;
            end
            QUAD_1: begin
                cos_val = -word_in.y;
                sin_val = word_in.x;
            end
            QUAD_2: begin
                cos_val = -word_in.x;
                sin_val = -word_in.y;
            end
            QUAD_3: begin
                cos_val = word_in.y;
                sin_val = -word_in.x;
            end
            default: begin
                cos_val = word_in.x;
                sin_val = word_in.y;
            end
        endcase
        ac_next = 48'(word_in.alpha * cos_val);
        as_next = 48'(word_in.alpha * sin_val);
        bc_next = 48'(word_in.beta * cos_val);
        bs_next = 48'(word_in.beta * sin_val);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ac_reg <= ac_next;
            as_reg <= as_next;
            bc_reg <= bc_next;
            bs_reg <= bs_next;
        end
    end

    // round half up, then keep the low 17 bits of the floor shift by 30
    always_comb begin
        d_sum = 49'(ac_reg) + 49'(bs_reg);
        q_sum = 49'(bc_reg) - 49'(as_reg);
        d_rnd = d_sum + (49'sd1 <<< 29);
        q_rnd = q_sum + (49'sd1 <<< 29);
        direct_next     = d_rnd[46:30];
        quadrature_next = q_rnd[46:30];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            direct_reg     <= direct_next;
            quadrature_reg <= quadrature_next;
        end
    end

    assign direct_out     = direct_reg;
    assign quadrature_out = quadrature_reg;

endmodule

// File: src/park_transform_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// park_transform_top
// Park transform: rotates a q1.15 (alpha, beta) vector by a 16-bit binary
// rotor angle into 17-bit (d, q).
// ----------------------------------------------------------------------------
// The block takes one sample per clock unless it is holding, and passes each
// accepted sample through the angle fold register, the cordic micro-rotation
// registers, the product registers and the rounded sum register, in order.
// The whole pipeline advances together; it holds when a finished word waits
// on m_ready, and s_ready is high whenever the output register is empty or
// being taken. No state is kept between samples.
module park_transform_top
    import pt_pkg::*;
#(
    parameter int SINCOS_STAGES = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_alpha_in,
    input  logic signed [15:0] s_beta_in,
    input  logic [15:0]        s_rotor_angle,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [16:0] m_direct_out,
    output logic signed [16:0] m_quadrature_out
);

    localparam int CORDIC_DEPTH =
        (SINCOS_STAGES < ATAN_ENTRIES) ? SINCOS_STAGES : ATAN_ENTRIES;
    // fold, cordic stages, products, sums
    localparam int LAST = CORDIC_DEPTH + 2;

    logic            pipe_en;
    logic [LAST:0]   valid_reg;
    logic [LAST:0]   valid_next;
    pt_cordic_t      cordic_pipe [0:CORDIC_DEPTH];

    assign pipe_en = !valid_reg[LAST] || m_ready;
    assign s_ready = pipe_en;
    assign m_valid = valid_reg[LAST];

    always_comb begin
        valid_next = valid_reg;
        if (pipe_en) begin
            valid_next = {valid_reg[LAST-1:0], s_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    pt_fold u_fold (
        .aclk        (aclk),
        .en          (pipe_en),
        .alpha_in    (s_alpha_in),
        .beta_in     (s_beta_in),
        .rotor_angle (s_rotor_angle),
        .word_out    (cordic_pipe[0])
    );

    for (genvar k = 0; k < CORDIC_DEPTH; k++) begin : g_cordic
        pt_cordic_stage #(
            .STAGE_IDX (k)
        ) u_stage (
            .aclk     (aclk),
            .en       (pipe_en),
            .word_in  (cordic_pipe[k]),
            .word_out (cordic_pipe[k+1])
        );
    end

    pt_rotate u_rotate (
        .aclk           (aclk),
        .en             (pipe_en),
        .word_in        (cordic_pipe[CORDIC_DEPTH]),
        .direct_out     (m_direct_out),
        .quadrature_out (m_quadrature_out)
    );

    // an accepted word lands in the fold stage
    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> valid_reg[0])
        else $error("accepted word did not enter the pipeline");

    // a stalled pipeline keeps every valid bit
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !pipe_en |=> $stable(valid_reg))
        else $error("valid bits moved during a stall");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && valid_reg == '0)
        else $error("pipeline not empty after reset");

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for park_transform_top. A short directed table covers
// full-scale vectors, octant and quadrant edges and the largest output
// magnitude, then random words follow under four pacing phases. Each result is
// compared with a bit-accurate bench cordic rotation, or zero for zero vectors.
// ----------------------------------------------------------------------------
module testbench
    import pt_pkg::*;
();

    localparam int    STAGES     = 16;
    localparam int    LATENCY    = ((STAGES < ATAN_ENTRIES) ? STAGES : ATAN_ENTRIES) + 3;
    localparam int    RANDOM_PER_PHASE = 458;
    localparam int    IDLE_LIMIT = 2000;
    localparam longint ROUND_HALF = 64'sd536870912;

    typedef struct packed {
        logic signed [16:0] direct;
        logic signed [16:0] quadrature;
    } dq_word_t;

    typedef struct packed {
        logic signed [15:0] alpha;
        logic signed [15:0] beta;
        logic [15:0]        angle;
        logic               known;
        logic signed [16:0] direct;
        logic signed [16:0] quadrature;
    } stim_row_t;

    // zero vectors give zero at any angle; the rest go through the rotation model
    localparam stim_row_t DIRECTED [22] = '{
        '{16'sh0000, 16'sh0000, 16'd0,     1'b1, 17'sd0, 17'sd0},
        '{16'sh0000, 16'sh0000, 16'h3039,  1'b1, 17'sd0, 17'sd0},
        '{16'sh0000, 16'sh0000, 16'hFFFF,  1'b1, 17'sd0, 17'sd0},
        '{16'sh7FFF, 16'sh0000, 16'd0,     1'b0, 17'sd0, 17'sd0},
        '{16'sh8000, 16'sh0000, 16'd0,     1'b0, 17'sd0, 17'sd0},
        '{16'sh0000, 16'sh7FFF, 16'd0,     1'b0, 17'sd0, 17'sd0},
        '{16'sh0000, 16'sh8000, 16'd16384, 1'b0, 17'sd0, 17'sd0},
        '{16'sh7FFF, 16'sh7FFF, 16'd0,     1'b0, 17'sd0, 17'sd0},
        '{16'sh8000, 16'sh8000, 16'd8192,  1'b0, 17'sd0, 17'sd0},
        '{16'sh7FFF, 16'sh8000, 16'd57344, 1'b0, 17'sd0, 17'sd0},
        '{16'sh8000, 16'sh7FFF, 16'd24576, 1'b0, 17'sd0, 17'sd0},
        '{16'sh7FFF, 16'sh7FFF, 16'd8191,  1'b0, 17'sd0, 17'sd0},
        '{16'sh7FFF, 16'sh7FFF, 16'd57343, 1'b0, 17'sd0, 17'sd0},
        '{16'sh8000, 16'sh8000, 16'd32768, 1'b0, 17'sd0, 17'sd0},
        '{16'sh8000, 16'sh8000, 16'd40960, 1'b0, 17'sd0, 17'sd0},
        '{16'sh8000, 16'sh8000, 16'd49152, 1'b0, 17'sd0, 17'sd0},
        '{16'sh7FFF, 16'sh8000, 16'd65535, 1'b0, 17'sd0, 17'sd0},
        '{16'shFFFF, 16'sh0001, 16'd16383, 1'b0, 17'sd0, 17'sd0},
        '{16'sh0001, 16'shFFFF, 16'd16385, 1'b0, 17'sd0, 17'sd0},
        '{16'sh5555, 16'shAAAA, 16'h5555,  1'b0, 17'sd0, 17'sd0},
        '{16'shAAAA, 16'sh5555, 16'hAAAA,  1'b0, 17'sd0, 17'sd0},
        '{16'sh8000, 16'sh7FFF, 16'd49151, 1'b0, 17'sd0, 17'sd0}
    };

    localparam longint ARCTAN_TURNS [24] = '{
        64'sh20000000, 64'sh12E4051E, 64'sh09FB385B, 64'sh051111D4,
        64'sh028B0D43, 64'sh0145D7E1, 64'sh00A2F61E, 64'sh00517C55,
        64'sh0028BE53, 64'sh00145F2F, 64'sh000A2F98, 64'sh000517CC,
        64'sh00028BE6, 64'sh000145F3, 64'sh0000A2FA, 64'sh0000517D,
        64'sh000028BE, 64'sh0000145F, 64'sh00000A30, 64'sh00000518,
        64'sh0000028C, 64'sh00000146, 64'sh000000A3, 64'sh00000051
    };

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic signed [15:0] s_alpha_in = '0;
    logic signed [15:0] s_beta_in = '0;
    logic [15:0]        s_rotor_angle = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [16:0] m_direct_out;
    logic signed [16:0] m_quadrature_out;

    dq_word_t dq_expected [$];
    int       sender_idle_pct = 0;
    int       receiver_stall_pct = 0;
    int       mismatches = 0;
    int       words_sent = 0;
    int       results_checked = 0;
    int       quiet_cycles = 0;

    park_transform_top #(
        .SINCOS_STAGES(STAGES)
    ) dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_alpha_in       (s_alpha_in),
        .s_beta_in        (s_beta_in),
        .s_rotor_angle    (s_rotor_angle),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_direct_out     (m_direct_out),
        .m_quadrature_out (m_quadrature_out)
    );

    always #5 aclk = ~aclk;

    // sine and cosine in q1.30 from an octant-centred cordic
    function automatic void cordic_sincos(input logic [15:0] angle,
                                          output longint cos_q30,
                                          output longint sin_q30);
        logic [15:0] folded;
        longint      x;
        longint      y;
        longint      z;
        longint      dx;
        longint      dy;
        folded = angle + EIGHTH_TURN;
        x = 64'sd652032874;
        y = 0;
        z = (longint'(folded[13:0]) - 8192) * 65536;
        for (int i = 0; i < STAGES && i < 24; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - ARCTAN_TURNS[i];
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + ARCTAN_TURNS[i];
            end
        end
        case (pt_quad_t'(folded[15:14]))
            QUAD_0: begin cos_q30 = x;  sin_q30 = y;  end
            QUAD_1: begin cos_q30 = -y; sin_q30 = x;  end
            QUAD_2: begin cos_q30 = -x; sin_q30 = -y; end
            default: begin cos_q30 = y; sin_q30 = -x; end
        endcase
    endfunction

    function automatic dq_word_t rotate_to_rotor_frame(input logic signed [15:0] alpha,
                                                       input logic signed [15:0] beta,
                                                       input logic [15:0] angle);
        longint   a;
        longint   b;
        longint   c;
        longint   s;
        longint   d_sum;
        longint   q_sum;
        dq_word_t w;
        a = alpha;
        b = beta;
        cordic_sincos(angle, c, s);
        d_sum = (a * c + b * s + ROUND_HALF) >>> 30;
        q_sum = (b * c - a * s + ROUND_HALF) >>> 30;
        w.direct = d_sum[16:0];
        w.quadrature = q_sum[16:0];
        return w;
    endfunction

    task automatic send_word(input logic signed [15:0] alpha, input logic signed [15:0] beta,
                             input logic [15:0] angle, input logic known,
                             input dq_word_t typed);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            s_alpha_in <= 16'($urandom);
            s_beta_in <= 16'($urandom);
            s_rotor_angle <= 16'($urandom);
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_alpha_in <= alpha;
        s_beta_in <= beta;
        s_rotor_angle <= angle;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        dq_expected.push_back(known ? typed : rotate_to_rotor_frame(alpha, beta, angle));
        words_sent++;
    endtask

    task automatic send_random_word();
        logic signed [15:0] alpha;
        logic signed [15:0] beta;
        logic [15:0]        angle;
        int                 pick;
        int                 octant;
        pick = $urandom_range(99);
        alpha = 16'($urandom);
        beta = 16'($urandom);
        angle = 16'($urandom);
        if (pick < 15) begin
            case ($urandom_range(4))
                0: alpha = 16'sh8000;
                1: alpha = 16'sh7FFF;
                2: alpha = 16'sh0000;
                3: alpha = 16'shFFFF;
                default: alpha = 16'sh0001;
            endcase
            case ($urandom_range(4))
                0: beta = 16'sh8000;
                1: beta = 16'sh7FFF;
                2: beta = 16'sh0000;
                3: beta = 16'shFFFF;
                default: beta = 16'sh0001;
            endcase
        end else if (pick < 40) begin
            // land on or next to an octant edge, where the fold changes quadrant or the residual changes sign
            octant = $urandom_range(7);
            angle = 16'(octant * 8192 + $urandom_range(4) - 2);
        end
        send_word(alpha, beta, angle, 1'b0, '0);
    endtask

    // output side: random back-pressure and in-order comparison
    always @(posedge aclk) begin
        m_ready <= aresetn && ($urandom_range(99) >= receiver_stall_pct);
    end

    always @(posedge aclk) begin
        dq_word_t w;
        if (aresetn && m_valid && m_ready) begin
            if (dq_expected.size() == 0) begin
                $error("result with nothing outstanding: direct_out %0d quadrature_out %0d",
                       m_direct_out, m_quadrature_out);
                mismatches++;
            end else begin
                w = dq_expected.pop_front();
                results_checked++;
                if (m_direct_out !== w.direct) begin
                    $error("direct_out: expected %0d, got %0d", w.direct, m_direct_out);
                    mismatches++;
                end
                if (m_quadrature_out !== w.quadrature) begin
                    $error("quadrature_out: expected %0d, got %0d",
                           w.quadrature, m_quadrature_out);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        @(posedge aclk);
        while (quiet_cycles < IDLE_LIMIT) @(posedge aclk);
        $display("hung: no word moved for %0d cycles", IDLE_LIMIT);
        $display("testbench NOT OK");
        $finish;
    end

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (DIRECTED[i]) begin
            send_word(DIRECTED[i].alpha, DIRECTED[i].beta, DIRECTED[i].angle,
                      DIRECTED[i].known, '{DIRECTED[i].direct, DIRECTED[i].quadrature});
        end

        // pacing phases: free-running, sender gaps, receiver stalls, light both
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 66; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 66; end
                default: begin sender_idle_pct = 7; receiver_stall_pct = 7; end
            endcase
            repeat (RANDOM_PER_PHASE) send_random_word();
        end
        s_valid <= 1'b0;
        receiver_stall_pct = 0;

        while (dq_expected.size() != 0) @(posedge aclk);
        repeat (2 * LATENCY) @(posedge aclk);

        $display("%0d words sent (directed edges, octant boundaries, random), %0d results compared",
                 words_sent, results_checked);
        $display("pacing: free-running, sender gaps, receiver stalls, mixed; %0d mismatches",
                 mismatches);
        if (mismatches == 0 && dq_expected.size() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

// File: files.f
src/pt_pkg.sv
src/pt_fold.sv
src/pt_cordic_stage.sv
src/pt_rotate.sv
src/park_transform_top.sv
tb/testbench.sv
